[hdl/window_median_filter_macros.svh]
// ============================================================================
// Window median filter assertion macros
// Shared concurrent assertion forms for the window median filter.
// ============================================================================
`ifndef WINDOW_MEDIAN_FILTER_MACROS_SVH
`define WINDOW_MEDIAN_FILTER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off while reset is held.
`define WMF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while reset is held.
`define WMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/wmf_pkg.sv]
// ============================================================================
// Window median filter package
// Types and fixed constants shared by the window median filter modules.
// ============================================================================
package wmf_pkg;

    localparam int PIX_W      = 8;
    localparam int SIZE_W     = 11;
    localparam int HALF_W     = 2;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;
    localparam int FIFO_DEPTH = 16;

    typedef logic [1:0] t_reg_idx;

    localparam t_reg_idx REG_IMAGE_WIDTH  = 2'd0;
    localparam t_reg_idx REG_IMAGE_HEIGHT = 2'd1;
    localparam t_reg_idx REG_HALF_WIDTH   = 2'd2;
    localparam t_reg_idx REG_HALF_HEIGHT  = 2'd3;

    typedef struct packed {
        logic emit;
        logic interior;
        logic last;
    } t_meta;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } t_result;

endpackage

[hdl/wmf_ram.sv]
// ============================================================================
// Generic RAM
// Single write port, single read port, registered read data.
// ============================================================================
module wmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/wmf_window.sv]
// ============================================================================
// Window median filter line store and window
// Keeps the rows above each column in a RAM and shifts columns into the window.
// ============================================================================
module wmf_window #(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_HALF    = 3
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_take,
    input  logic [$clog2(MAX_COLUMNS)-1:0]        i_col,
    input  logic [wmf_pkg::PIX_W-1:0]             i_pixel,
    input  wmf_pkg::t_meta                        i_meta,
    output logic [(2*MAX_HALF+1)*(2*MAX_HALF+1)*wmf_pkg::PIX_W-1:0] o_samples,
    output wmf_pkg::t_meta                        o_meta
);
    import wmf_pkg::*;

    localparam int WIN = 2 * MAX_HALF + 1;
    localparam int LW  = PIX_W * 2 * MAX_HALF;
    localparam int CB  = PIX_W * WIN;
    localparam int XW  = $clog2(MAX_COLUMNS);

    logic              r_s1_take;
    logic [XW-1:0]     r_s1_col;
    logic [PIX_W-1:0]  r_s1_pix;
    t_meta             r_s1_meta;
    logic              r_fwd_valid;
    logic [XW-1:0]     r_fwd_col;
    logic [LW-1:0]     r_fwd_data;
    logic [LW-1:0]     ram_rdata;
    logic [LW-1:0]     rd;
    logic [LW-1:0]     wdata;
    logic [CB-1:0]     col_vec;
    logic [WIN-1:0][CB-1:0] r_win;
    t_meta             r_s2_meta;

    wmf_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_COLUMNS)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (r_s1_take),
        .i_waddr (r_s1_col),
        .i_wdata (wdata),
        .i_raddr (i_col),
        .o_rdata (ram_rdata)
    );

    // The previous beat may have written this column in the cycle of our read.
    assign rd      = (r_fwd_valid && (r_fwd_col == r_s1_col)) ? r_fwd_data : ram_rdata;
    assign wdata   = {rd[LW-PIX_W-1:0], r_s1_pix};
    assign col_vec = {rd, r_s1_pix};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_take   <= 1'b0;
            r_s1_meta   <= '0;
            r_fwd_valid <= 1'b0;
            r_s2_meta   <= '0;
        end else begin
            r_s1_take   <= i_take;
            r_s1_meta   <= i_meta;
            r_fwd_valid <= r_s1_take;
            r_s2_meta   <= r_s1_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_col   <= i_col;
        r_s1_pix   <= i_pixel;
        r_fwd_col  <= r_s1_col;
        r_fwd_data <= wdata;
        if (r_s1_take) begin
            r_win <= {r_win[WIN-2:0], col_vec};
        end
    end

    assign o_samples = r_win;
    assign o_meta    = r_s2_meta;

endmodule

[hdl/wmf_median.sv]
// ============================================================================
// Window median filter rank selector
// Finds the middle sample one bit per stage, most significant bit first.
// ============================================================================
module wmf_median #(
    parameter int MAX_HALF = 3
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [(2*MAX_HALF+1)*(2*MAX_HALF+1)*wmf_pkg::PIX_W-1:0] i_samples,
    input  logic [wmf_pkg::HALF_W-1:0]            i_half_w,
    input  logic [wmf_pkg::HALF_W-1:0]            i_half_h,
    input  wmf_pkg::t_meta                        i_meta,
    output wmf_pkg::t_meta                        o_meta,
    output logic [wmf_pkg::PIX_W-1:0]             o_median
);
    import wmf_pkg::*;

    localparam int WIN   = 2 * MAX_HALF + 1;
    localparam int NS    = WIN * WIN;
    localparam int CNW   = $clog2(NS + 1);
    localparam int NSTEP = PIX_W;

    logic [NS-1:0]       in_mask;
    logic [CNW-1:0]      in_rank;
    logic [NS*PIX_W-1:0] r_samp [1:NSTEP-1];
    logic [NS-1:0]       r_mask [1:NSTEP-1];
    logic [CNW-1:0]      r_rank [1:NSTEP-1];
    logic [PIX_W-1:0]    r_res  [1:NSTEP];
    t_meta               r_meta [1:NSTEP];

    always_comb begin
        for (int j = 0; j < WIN; j++) begin
            for (int k = 0; k < WIN; k++) begin
                in_mask[j*WIN+k] = (j <= 2 * int'(i_half_w)) && (k <= 2 * int'(i_half_h));
            end
        end
        in_rank = CNW'(2 * 32'(i_half_w) * 32'(i_half_h) + 32'(i_half_w) + 32'(i_half_h));
    end

    for (genvar s = 0; s < NSTEP; s++) begin : g_step
        localparam int B = NSTEP - 1 - s;

        logic [NS*PIX_W-1:0] cur_samp;
        logic [NS-1:0]       cur_mask;
        logic [CNW-1:0]      cur_rank;
        logic [PIX_W-1:0]    cur_res;
        t_meta               cur_meta;
        logic [CNW-1:0]      cnt0;
        logic                bit_one;
        logic [NS-1:0]       n_mask;
        logic [CNW-1:0]      n_rank;
        logic [PIX_W-1:0]    n_res;

        if (s == 0) begin : g_first
            assign cur_samp = i_samples;
            assign cur_mask = in_mask;
            assign cur_rank = in_rank;
            assign cur_res  = '0;
            assign cur_meta = i_meta;
        end else begin : g_next
            assign cur_samp = r_samp[s];
            assign cur_mask = r_mask[s];
            assign cur_rank = r_rank[s];
            assign cur_res  = r_res[s];
            assign cur_meta = r_meta[s];
        end

        always_comb begin
            cnt0 = '0;
            for (int i = 0; i < NS; i++) begin
                cnt0 = cnt0 + CNW'(cur_mask[i] & ~cur_samp[i*PIX_W+B]);
            end
            bit_one = (cur_rank >= cnt0);
            n_rank  = bit_one ? (cur_rank - cnt0) : cur_rank;
            for (int i = 0; i < NS; i++) begin
                n_mask[i] = cur_mask[i] & (cur_samp[i*PIX_W+B] == bit_one);
            end
            n_res    = cur_res;
            n_res[B] = bit_one;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_meta[s+1] <= '0;
            end else begin
                r_meta[s+1] <= cur_meta;
            end
        end

        always_ff @(posedge i_clk) begin
            r_res[s+1] <= n_res;
        end

        if (s < NSTEP - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_samp[s+1] <= cur_samp;
                r_mask[s+1] <= n_mask;
                r_rank[s+1] <= n_rank;
            end
        end
    end

    assign o_meta   = r_meta[NSTEP];
    assign o_median = r_res[NSTEP];

endmodule

[hdl/wmf_fifo.sv]
// ============================================================================
// Window median filter output queue
// Small register queue that holds finished results until the receiver takes them.
// ============================================================================
module wmf_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wmf_pkg::t_result  i_data,
    output logic              o_valid,
    output wmf_pkg::t_result  o_data,
    input  logic              i_pop
);
    import wmf_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    t_result       r_mem [FIFO_DEPTH];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic          pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + AW'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + AW'(1);
            end
            r_count <= r_count + CW'(i_push) - CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

[hdl/window_median_filter.sv]
// ============================================================================
// Window median filter
// Streaming 2-D median filter over 8-bit gray pixels in raster order.
// ----------------------------------------------------------------------------
// The input channel carries one beat per pixel (command 0) or per flush
// (command 1). Flushes are sent after the last pixel to drain the border
// zeros that trail the image. The output channel gives one beat per image
// position, the window median or 0 at the border, and marks the final beat.
// Output positions trail the source by half_height rows plus half_width
// pixels. A beat that produces a result passes through the line store read,
// the window column shift, the bitwise rank search and the queue write
// before it shows on the output. The block takes one beat every cycle
// while o_in_stall is low. Pixels go through a single-port read,
// single-port write line store addressed by column.
// Results wait in a 16-entry queue; the input stalls only when 16 results
// are in flight or waiting, so a stalled receiver stops the input once the
// queue is full and nothing is lost.
// Reset sets the registers to 1024, 1024, 1, 1 and restarts the image; the
// line store is not cleared. Configuration writes restart the image.
// ============================================================================
`include "window_median_filter_macros.svh"

module window_median_filter #(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024,
    parameter int MAX_HALF    = 3
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_command,
    input  logic [wmf_pkg::PIX_W-1:0]          i_pixel_in,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [wmf_pkg::PIX_W-1:0]          o_pixel_out,
    output logic                               o_last_pixel,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [wmf_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [wmf_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [wmf_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import wmf_pkg::*;

    localparam int WIN = 2 * MAX_HALF + 1;
    localparam int NS  = WIN * WIN;
    localparam int XW  = $clog2(MAX_COLUMNS);
    localparam int YW  = $clog2(MAX_ROWS);
    localparam int CW  = $clog2(MAX_COLUMNS + 1);
    localparam int RW  = $clog2(MAX_ROWS + 1);
    localparam int PW  = $clog2(MAX_COLUMNS * MAX_ROWS + 1);
    localparam int UW  = $clog2(FIFO_DEPTH + 1);
    localparam int XE  = XW + 2;
    localparam int YE  = YW + 2;

    logic [SIZE_W-1:0] r_img_w;
    logic [SIZE_W-1:0] r_img_h;
    logic [HALF_W-1:0] r_half_w;
    logic [HALF_W-1:0] r_half_h;

    logic [CW-1:0]     w_eff;
    logic [RW-1:0]     h_eff;
    logic [HALF_W-1:0] hw_eff;
    logic [HALF_W-1:0] hh_eff;
    logic [PW-1:0]     lag;
    logic [PW-1:0]     total;

    logic [XW-1:0] r_in_col,  n_in_col;
    logic [YW-1:0] r_in_row,  n_in_row;
    logic [PW-1:0] r_in_pos,  n_in_pos;
    logic          r_in_done, n_in_done;
    logic [XW-1:0] r_out_col, n_out_col;
    logic [YW-1:0] r_out_row, n_out_row;
    logic [PW-1:0] r_out_pos, n_out_pos;
    logic [UW-1:0] r_used,    n_used;

    logic    cfg_we;
    logic    in_accept;
    logic    out_accept;
    logic    px_take;
    logic    emit;
    logic    out_last;
    logic    interior;
    t_meta   s0_meta;

    logic [NS*PIX_W-1:0] win_samples;
    t_meta               win_meta;
    t_meta               med_meta;
    logic [PIX_W-1:0]    med_value;
    t_result             push_data;
    t_result             fifo_data;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w  <= SIZE_W'(1024);
            r_img_h  <= SIZE_W'(1024);
            r_half_w <= HALF_W'(1);
            r_half_h <= HALF_W'(1);
        end else if (cfg_we) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_IMAGE_WIDTH:  r_img_w  <= pwdata[SIZE_W-1:0];
                REG_IMAGE_HEIGHT: r_img_h  <= pwdata[SIZE_W-1:0];
                REG_HALF_WIDTH:   r_half_w <= pwdata[HALF_W-1:0];
                REG_HALF_HEIGHT:  r_half_h <= pwdata[HALF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_IMAGE_WIDTH:  prdata = CFG_DATA_W'(r_img_w);
            REG_IMAGE_HEIGHT: prdata = CFG_DATA_W'(r_img_h);
            REG_HALF_WIDTH:   prdata = CFG_DATA_W'(r_half_w);
            REG_HALF_HEIGHT:  prdata = CFG_DATA_W'(r_half_h);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Effective sizes
    // ------------------------------------------------------------------
    always_comb begin
        if (r_img_w == '0) begin
            w_eff = CW'(1);
        end else if (32'(r_img_w) > MAX_COLUMNS) begin
            w_eff = CW'(MAX_COLUMNS);
        end else begin
            w_eff = CW'(r_img_w);
        end
        if (r_img_h == '0) begin
            h_eff = RW'(1);
        end else if (32'(r_img_h) > MAX_ROWS) begin
            h_eff = RW'(MAX_ROWS);
        end else begin
            h_eff = RW'(r_img_h);
        end
        hw_eff = (32'(r_half_w) > MAX_HALF) ? HALF_W'(MAX_HALF) : r_half_w;
        hh_eff = (32'(r_half_h) > MAX_HALF) ? HALF_W'(MAX_HALF) : r_half_h;
        lag    = PW'(hh_eff) * PW'(w_eff) + PW'(hw_eff);
        total  = PW'(w_eff) * PW'(h_eff);
    end

    // ------------------------------------------------------------------
    // Position tracking
    // ------------------------------------------------------------------
    assign o_in_stall = (r_used >= UW'(FIFO_DEPTH));
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_accept = o_out_valid && !i_out_stall;
    assign px_take    = in_accept && !i_command && !r_in_done;
    assign emit       = (px_take && (r_in_pos >= lag)) || (in_accept && i_command && r_in_done);
    assign out_last   = (r_out_pos == total - PW'(1));

    assign interior = (YE'(r_out_row) >= YE'(hh_eff))
                   && (YE'(r_out_row) + YE'(hh_eff) < YE'(h_eff))
                   && (XE'(r_out_col) >= XE'(hw_eff))
                   && (XE'(r_out_col) + XE'(hw_eff) < XE'(w_eff));

    assign s0_meta = '{emit: emit, interior: interior, last: out_last};

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_in_pos  = r_in_pos;
        n_in_done = r_in_done;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_out_pos = r_out_pos;
        n_used    = r_used + UW'(emit) - UW'(out_accept);
        if (px_take) begin
            n_in_pos = r_in_pos + PW'(1);
            if (r_in_col == XW'(w_eff - CW'(1))) begin
                n_in_col = '0;
                if (r_in_row == YW'(h_eff - RW'(1))) begin
                    n_in_done = 1'b1;
                end else begin
                    n_in_row = r_in_row + YW'(1);
                end
            end else begin
                n_in_col = r_in_col + XW'(1);
            end
        end
        if (emit) begin
            n_out_pos = r_out_pos + PW'(1);
            if (r_out_col == XW'(w_eff - CW'(1))) begin
                n_out_col = '0;
                n_out_row = r_out_row + YW'(1);
            end else begin
                n_out_col = r_out_col + XW'(1);
            end
        end
        if (cfg_we || (emit && out_last)) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_in_pos  = '0;
            n_in_done = 1'b0;
            n_out_col = '0;
            n_out_row = '0;
            n_out_pos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_in_pos  <= '0;
            r_in_done <= 1'b0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_out_pos <= '0;
            r_used    <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_in_pos  <= n_in_pos;
            r_in_done <= n_in_done;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_out_pos <= n_out_pos;
            r_used    <= n_used;
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    wmf_window #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_HALF    (MAX_HALF)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (px_take),
        .i_col     (r_in_col),
        .i_pixel   (i_pixel_in),
        .i_meta    (s0_meta),
        .o_samples (win_samples),
        .o_meta    (win_meta)
    );

    wmf_median #(
        .MAX_HALF (MAX_HALF)
    ) u_median (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_samples (win_samples),
        .i_half_w  (hw_eff),
        .i_half_h  (hh_eff),
        .i_meta    (win_meta),
        .o_meta    (med_meta),
        .o_median  (med_value)
    );

    assign push_data = '{pixel: med_meta.interior ? med_value : '0, last: med_meta.last};

    wmf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (med_meta.emit),
        .i_data  (push_data),
        .o_valid (o_out_valid),
        .o_data  (fifo_data),
        .i_pop   (!i_out_stall)
    );

    assign o_pixel_out  = fifo_data.pixel;
    assign o_last_pixel = fifo_data.last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `WMF_ASSERT_IMP(a_used_bound, 1'b1, r_used <= UW'(FIFO_DEPTH), "result credit count overflow")
    `WMF_ASSERT_IMP(a_out_backed, o_out_valid, r_used != '0, "output beat without a credit")
    `WMF_ASSERT_NEXT(a_cfg_restart, cfg_we, (r_in_pos == '0) && (r_out_pos == '0) && !r_in_done, "image not restarted")

endmodule
